// ===== hdl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants for the quaternion rotate and multiply pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int QW  = 32;          // component width
    localparam int PW  = 2 * QW;      // pair product width
    localparam int CW  = PW + 2;      // coefficient width (sum of pair products)
    localparam int LOW = QW + 1;      // low slice of a coefficient, unsigned
    localparam int HW  = CW - LOW;    // high slice of a coefficient, signed
    localparam int AW  = 100;         // term and accumulator width
    localparam int SW  = 72;          // pre-saturation width
    localparam int NPP = 16;          // pair multipliers
    localparam int NCF = 9;           // coefficients
    localparam int NST = 6;           // pipeline stages

    localparam int ROT_SHIFT  = 59;
    localparam int PROD_SHIFT = 30;

    typedef enum logic [1:0] {
        CMD_ROT      = 2'd0,
        CMD_ROT_CONJ = 2'd1,
        CMD_PROD     = 2'd2
    } t_cmd;

    // component order inside a quaternion
    localparam logic [1:0] C_W = 2'd0;
    localparam logic [1:0] C_X = 2'd1;
    localparam logic [1:0] C_Y = 2'd2;
    localparam logic [1:0] C_Z = 2'd3;

    // multiplier slots used when rotating
    localparam logic [3:0] PP_YY = 4'd0;
    localparam logic [3:0] PP_ZZ = 4'd1;
    localparam logic [3:0] PP_XY = 4'd2;
    localparam logic [3:0] PP_WZ = 4'd3;
    localparam logic [3:0] PP_WY = 4'd4;
    localparam logic [3:0] PP_XZ = 4'd5;
    localparam logic [3:0] PP_XX = 4'd6;
    localparam logic [3:0] PP_WX = 4'd7;
    localparam logic [3:0] PP_YZ = 4'd8;

    // multiplier slot of q_i * b_j in product mode
    function automatic logic [3:0] pq(input logic [1:0] i, input logic [1:0] j);
        return {i, j};
    endfunction

    typedef struct packed {
        logic [1:0]           cmd;
        logic signed [QW-1:0] q_w;
        logic signed [QW-1:0] q_x;
        logic signed [QW-1:0] q_y;
        logic signed [QW-1:0] q_z;
        logic signed [QW-1:0] b_w;
        logic signed [QW-1:0] b_x;
        logic signed [QW-1:0] b_y;
        logic signed [QW-1:0] b_z;
    } t_in;

    typedef struct packed {
        logic signed [QW-1:0] r_w;
        logic signed [QW-1:0] r_x;
        logic signed [QW-1:0] r_y;
        logic signed [QW-1:0] r_z;
        logic                 saturated;
    } t_out;

    // command and vector travelling alongside the arithmetic
    typedef struct packed {
        logic [1:0]           cmd;
        logic signed [QW-1:0] v_x;
        logic signed [QW-1:0] v_y;
        logic signed [QW-1:0] v_z;
    } t_ctl;

endpackage

// ===== hdl/qrm_if.sv =====
// ----------------------------------------------------------------------------
// qrm_in_if / qrm_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface qrm_in_if;
    import qrm_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qrm_out_if;
    import qrm_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/quaternion_rotate_and_multiply.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_and_multiply
// Fixed-point quaternion vector rotation and Hamilton product.
// ----------------------------------------------------------------------------
// Input channel i_in carries a command, a Q2.30 quaternion q and a second
// operand b. Command rotate turns the Q16.16 vector (b_x, b_y, b_z) by q,
// rotate-by-conjugate uses the conjugate of q, product forms q * b in Q2.30.
// An unused command yields an all-zero result item.
// Output channel o_out carries one result item per input item, saturated to
// 32 bits with a flag when any component was clipped.
// An accepted item passes through the stages in order: pair multipliers,
// coefficient fold, split coefficient-by-vector multipliers, term recombine,
// axis sum with rounding, and scale/saturate into the result register.
// Throughput is one item per cycle unless stalled; a stage holds one item.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on o_out only backs up as far as the first empty stage and the input
// keeps accepting items until all six stages are full.
// Reset clears the valid bits of all stages; nothing else needs reset.
// ----------------------------------------------------------------------------
module quaternion_rotate_and_multiply (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qrm_in_if.sink           i_in,
    qrm_out_if.source        o_out
);
    import qrm_pkg::*;

    logic [NST-1:0]       en;
    logic [NST-1:0]       n_vld;
    logic [NST-1:0]       r_vld;

    logic signed [PW-1:0] pp   [NPP];
    logic signed [CW-1:0] cf   [NCF];
    logic signed [AW-1:0] term [NCF];
    t_ctl                 ctl_pp;
    t_ctl                 ctl_cf;
    t_ctl                 ctl_term;
    t_out                 res;

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        if (en[0]) begin
            n_vld[0] = i_in.valid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    qrm_pair_mul u_pair_mul (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_item (i_in.data),
        .o_pp   (pp),
        .o_ctl  (ctl_pp)
    );

    qrm_coef u_coef (
        .i_clk (i_clk),
        .i_en  (en[1]),
        .i_pp  (pp),
        .i_ctl (ctl_pp),
        .o_cf  (cf),
        .o_ctl (ctl_cf)
    );

    qrm_scale u_scale (
        .i_clk    (i_clk),
        .i_en_mul (en[2]),
        .i_en_sum (en[3]),
        .i_cf     (cf),
        .i_ctl    (ctl_cf),
        .o_term   (term),
        .o_ctl    (ctl_term)
    );

    qrm_finish u_finish (
        .i_clk    (i_clk),
        .i_en_acc (en[4]),
        .i_en_out (en[5]),
        .i_term   (term),
        .i_ctl    (ctl_term),
        .o_res    (res)
    );

    assign i_in.ready  = en[0];
    assign o_out.valid = r_vld[NST-1];
    assign o_out.data  = res;

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item not captured by first stage");

    // a full pipeline facing a stalled receiver must refuse input
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while pipeline full and stalled");

    // the flag only goes with a component at a clip limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.saturated) |->
            (o_out.data.r_w == 32'h7fffffff || o_out.data.r_w == 32'h80000000 ||
             o_out.data.r_x == 32'h7fffffff || o_out.data.r_x == 32'h80000000 ||
             o_out.data.r_y == 32'h7fffffff || o_out.data.r_y == 32'h80000000 ||
             o_out.data.r_z == 32'h7fffffff || o_out.data.r_z == 32'h80000000))
        else $error("saturation flag without a clipped component");

endmodule

// ===== hdl/qrm_pair_mul.sv =====
// ----------------------------------------------------------------------------
// qrm_pair_mul
// Stage 1: sixteen 32x32 signed multipliers forming component pair products.
// ----------------------------------------------------------------------------
module qrm_pair_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  qrm_pkg::t_in                  i_item,
    output logic signed [qrm_pkg::PW-1:0] o_pp [qrm_pkg::NPP],
    output qrm_pkg::t_ctl                 o_ctl
);
    import qrm_pkg::*;

    logic signed [QW-1:0] qv    [4];
    logic signed [QW-1:0] bv    [4];
    logic signed [QW-1:0] op_a  [NPP];
    logic signed [QW-1:0] op_b  [NPP];
    logic signed [PW-1:0] n_pp  [NPP];
    logic signed [PW-1:0] r_pp  [NPP];
    t_ctl                 n_ctl;
    t_ctl                 r_ctl;

    always_comb begin
        qv[C_W] = i_item.q_w;
        qv[C_X] = i_item.q_x;
        qv[C_Y] = i_item.q_y;
        qv[C_Z] = i_item.q_z;
        bv[C_W] = i_item.b_w;
        bv[C_X] = i_item.b_x;
        bv[C_Y] = i_item.b_y;
        bv[C_Z] = i_item.b_z;
        for (int i = 0; i < NPP; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (i_item.cmd)
            CMD_PROD: begin
                for (int i = 0; i < 4; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        op_a[pq(2'(i), 2'(j))] = qv[i];
                        op_b[pq(2'(i), 2'(j))] = bv[j];
                    end
                end
            end
            default: begin
                op_a[PP_YY] = qv[C_Y]; op_b[PP_YY] = qv[C_Y];
                op_a[PP_ZZ] = qv[C_Z]; op_b[PP_ZZ] = qv[C_Z];
                op_a[PP_XY] = qv[C_X]; op_b[PP_XY] = qv[C_Y];
                op_a[PP_WZ] = qv[C_W]; op_b[PP_WZ] = qv[C_Z];
                op_a[PP_WY] = qv[C_W]; op_b[PP_WY] = qv[C_Y];
                op_a[PP_XZ] = qv[C_X]; op_b[PP_XZ] = qv[C_Z];
                op_a[PP_XX] = qv[C_X]; op_b[PP_XX] = qv[C_X];
                op_a[PP_WX] = qv[C_W]; op_b[PP_WX] = qv[C_X];
                op_a[PP_YZ] = qv[C_Y]; op_b[PP_YZ] = qv[C_Z];
            end
        endcase
        for (int i = 0; i < NPP; i++) begin
            n_pp[i] = op_a[i] * op_b[i];
        end
        n_ctl.cmd = i_item.cmd;
        n_ctl.v_x = i_item.b_x;
        n_ctl.v_y = i_item.b_y;
        n_ctl.v_z = i_item.b_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= n_pp;
            r_ctl <= n_ctl;
        end
    end

    assign o_pp  = r_pp;
    assign o_ctl = r_ctl;

endmodule

// ===== hdl/qrm_coef.sv =====
// ----------------------------------------------------------------------------
// qrm_coef
// Stage 2: folds pair products into rotation coefficients or product sums.
// ----------------------------------------------------------------------------
module qrm_coef (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [qrm_pkg::PW-1:0] i_pp [qrm_pkg::NPP],
    input  qrm_pkg::t_ctl                 i_ctl,
    output logic signed [qrm_pkg::CW-1:0] o_cf [qrm_pkg::NCF],
    output qrm_pkg::t_ctl                 o_ctl
);
    import qrm_pkg::*;

    logic signed [CW-1:0] e    [NPP];
    logic signed [CW-1:0] n_cf [NCF];
    logic signed [CW-1:0] r_cf [NCF];
    logic signed [CW-1:0] wad;
    logic signed [CW-1:0] wac;
    logic signed [CW-1:0] wab;
    logic                 conj;
    t_ctl                 r_ctl;

    always_comb begin
        for (int i = 0; i < NPP; i++) begin
            e[i] = CW'(i_pp[i]);
        end
        // conjugate flips the sign of every term carrying the scalar part
        conj = (i_ctl.cmd == CMD_ROT_CONJ);
        wad  = conj ? e[PP_WZ] : -e[PP_WZ];
        wac  = conj ? -e[PP_WY] : e[PP_WY];
        wab  = conj ? e[PP_WX] : -e[PP_WX];
        for (int i = 0; i < NCF; i++) begin
            n_cf[i] = '0;
        end
        case (i_ctl.cmd)
            CMD_PROD: begin
                n_cf[0] = e[pq(C_W, C_W)] - e[pq(C_X, C_X)]
                        - e[pq(C_Y, C_Y)] - e[pq(C_Z, C_Z)];
                n_cf[1] = e[pq(C_X, C_W)] + e[pq(C_W, C_X)]
                        + e[pq(C_Y, C_Z)] - e[pq(C_Z, C_Y)];
                n_cf[2] = e[pq(C_W, C_Y)] - e[pq(C_X, C_Z)]
                        + e[pq(C_Y, C_W)] + e[pq(C_Z, C_X)];
                n_cf[3] = e[pq(C_W, C_Z)] + e[pq(C_X, C_Y)]
                        - e[pq(C_Y, C_X)] + e[pq(C_Z, C_W)];
            end
            default: begin
                // row per output axis, column per vector component
                n_cf[0] = -(e[PP_YY] + e[PP_ZZ]);
                n_cf[1] = e[PP_XY] + wad;
                n_cf[2] = e[PP_XZ] + wac;
                n_cf[3] = e[PP_XY] - wad;
                n_cf[4] = -(e[PP_XX] + e[PP_ZZ]);
                n_cf[5] = e[PP_YZ] + wab;
                n_cf[6] = e[PP_XZ] - wac;
                n_cf[7] = e[PP_YZ] - wab;
                n_cf[8] = -(e[PP_XX] + e[PP_YY]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cf  <= n_cf;
            r_ctl <= i_ctl;
        end
    end

    assign o_cf  = r_cf;
    assign o_ctl = r_ctl;

endmodule

// ===== hdl/qrm_scale.sv =====
// ----------------------------------------------------------------------------
// qrm_scale
// Stages 3 and 4: coefficient times vector component, split into two
// partial products, then recombined into full-width terms.
// ----------------------------------------------------------------------------
module qrm_scale (
    input  logic                          i_clk,
    input  logic                          i_en_mul,
    input  logic                          i_en_sum,
    input  logic signed [qrm_pkg::CW-1:0] i_cf [qrm_pkg::NCF],
    input  qrm_pkg::t_ctl                 i_ctl,
    output logic signed [qrm_pkg::AW-1:0] o_term [qrm_pkg::NCF],
    output qrm_pkg::t_ctl                 o_ctl
);
    import qrm_pkg::*;

    logic signed [QW-1:0]      vsel  [3];
    logic signed [HW-1:0]      hi_op [NCF];
    logic signed [LOW:0]       lo_op [NCF];
    logic signed [HW+QW-1:0]   n_ph  [NCF];
    logic signed [LOW+QW:0]    n_pl  [NCF];
    logic signed [HW+QW-1:0]   r_ph  [NCF];
    logic signed [LOW+QW:0]    r_pl  [NCF];
    logic signed [AW-1:0]      hx    [NCF];
    logic signed [AW-1:0]      lx    [NCF];
    logic signed [AW-1:0]      n_t   [NCF];
    logic signed [AW-1:0]      r_t   [NCF];
    t_ctl                      r_ctl_mul;
    t_ctl                      r_ctl_sum;

    always_comb begin
        case (i_ctl.cmd)
            CMD_PROD: begin
                // product sums pass through as coefficient times one
                vsel[0] = QW'(1);
                vsel[1] = QW'(1);
                vsel[2] = QW'(1);
            end
            default: begin
                vsel[0] = i_ctl.v_x;
                vsel[1] = i_ctl.v_y;
                vsel[2] = i_ctl.v_z;
            end
        endcase
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                hi_op[3*a+c] = $signed(i_cf[3*a+c][CW-1:LOW]);
                lo_op[3*a+c] = $signed({1'b0, i_cf[3*a+c][LOW-1:0]});
                n_ph[3*a+c]  = hi_op[3*a+c] * vsel[c];
                n_pl[3*a+c]  = lo_op[3*a+c] * vsel[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_ph      <= n_ph;
            r_pl      <= n_pl;
            r_ctl_mul <= i_ctl;
        end
    end

    always_comb begin
        for (int i = 0; i < NCF; i++) begin
            hx[i]  = AW'(r_ph[i]);
            lx[i]  = AW'(r_pl[i]);
            n_t[i] = (hx[i] <<< LOW) + lx[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_t       <= n_t;
            r_ctl_sum <= r_ctl_mul;
        end
    end

    assign o_term = r_t;
    assign o_ctl  = r_ctl_sum;

endmodule

// ===== hdl/qrm_finish.sv =====
// ----------------------------------------------------------------------------
// qrm_finish
// Stages 5 and 6: per-axis sum with rounding bias, then scaling, vector add,
// saturation to 32 bits and the result register.
// ----------------------------------------------------------------------------
module qrm_finish (
    input  logic                          i_clk,
    input  logic                          i_en_acc,
    input  logic                          i_en_out,
    input  logic signed [qrm_pkg::AW-1:0] i_term [qrm_pkg::NCF],
    input  qrm_pkg::t_ctl                 i_ctl,
    output qrm_pkg::t_out                 o_res
);
    import qrm_pkg::*;

    localparam logic signed [AW-1:0] RND_ROT  = AW'(1) <<< (ROT_SHIFT - 1);
    localparam logic signed [AW-1:0] RND_PROD = AW'(1) <<< (PROD_SHIFT - 1);

    logic signed [AW-1:0] n_acc [4];
    logic signed [AW-1:0] r_acc [4];
    t_ctl                 r_ctl;

    logic                 rot;
    logic signed [QW-1:0] vk    [4];
    logic signed [AW-1:0] sh    [4];
    logic signed [SW-1:0] pre   [4];
    logic signed [QW-1:0] clip  [4];
    logic [3:0]           over;
    t_out                 n_res;
    t_out                 r_res;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_acc[k] = '0;
        end
        case (i_ctl.cmd)
            CMD_PROD: begin
                for (int k = 0; k < 4; k++) begin
                    n_acc[k] = i_term[k] + RND_PROD;
                end
            end
            CMD_ROT, CMD_ROT_CONJ: begin
                for (int a = 0; a < 3; a++) begin
                    n_acc[a+1] = i_term[3*a] + i_term[3*a+1] + i_term[3*a+2] + RND_ROT;
                end
            end
            default: begin
                for (int k = 0; k < 4; k++) begin
                    n_acc[k] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en_acc) begin
            r_acc <= n_acc;
            r_ctl <= i_ctl;
        end
    end

    always_comb begin
        rot   = (r_ctl.cmd == CMD_ROT) || (r_ctl.cmd == CMD_ROT_CONJ);
        vk[0] = '0;
        vk[1] = r_ctl.v_x;
        vk[2] = r_ctl.v_y;
        vk[3] = r_ctl.v_z;
        for (int k = 0; k < 4; k++) begin
            sh[k]  = rot ? (r_acc[k] >>> ROT_SHIFT) : (r_acc[k] >>> PROD_SHIFT);
            pre[k] = $signed(sh[k][SW-1:0]) + (rot ? SW'(vk[k]) : SW'(0));
            // fits when every bit above the sign position matches it
            over[k] = !((&pre[k][SW-1:QW-1]) || !(|pre[k][SW-1:QW-1]));
            if (over[k]) begin
                clip[k] = pre[k][SW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
            end else begin
                clip[k] = pre[k][QW-1:0];
            end
        end
        n_res.r_w       = clip[0];
        n_res.r_x       = clip[1];
        n_res.r_y       = clip[2];
        n_res.r_z       = clip[3];
        n_res.saturated = |over;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== test/tb_quaternion_rotate_and_multiply.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_rotate_and_multiply
// Self-checking bench for the quaternion rotation and Hamilton product block.
// ----------------------------------------------------------------------------
// Items go in through a valid/ready source that sends in random bursts, and
// results come out to a sink that stalls in changing patterns. Every accepted
// item is run through an exact wide-integer model of the rotation or product,
// and the predicted result is queued. Each result from the block is compared
// field by field with the oldest queued prediction. Directed items cover the
// field extremes, every command and the rounding and saturation corners;
// random items follow, mixing realistic, full-range and edge values.
// ----------------------------------------------------------------------------
module tb_quaternion_rotate_and_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import qrm_pkg::*;

    typedef logic signed [127:0] t_acc;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_SPARSE,
        RDY_PERIODIC,
        RDY_CHOKED
    } t_rdy_mode;

    localparam logic [1:0]           CMD_UNUSED  = 2'd3;
    localparam int                   N_RANDOM    = 600;
    localparam logic signed [QW-1:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [QW-1:0] ONE_Q16     = 32'sh0001_0000;
    localparam logic signed [QW-1:0] COS45_Q30   = 32'sd759250125;
    localparam logic signed [QW-1:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [QW-1:0] UNIT        = 32'sd1;
    localparam t_acc                 ROT_HALF    = 128'sd1 <<< (ROT_SHIFT - 1);
    localparam t_acc                 PROD_HALF   = 128'sd1 <<< (PROD_SHIFT - 1);
    localparam t_acc                 CLIP_HI     = 128'sd2147483647;
    localparam t_acc                 CLIP_LO     = -128'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qrm_in_if  in_ch ();
    qrm_out_if out_ch ();

    quaternion_rotate_and_multiply u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_out      predicted_results [$];
    int        n_mismatch;
    int        n_checked;
    int        n_saturated;
    int        n_by_cmd [4];
    int        burst_left;
    t_rdy_mode rdy_mode;
    int        rdy_phase_left;
    int        rdy_tick;

    // exact triple product, wide enough for any three 32-bit operands
    function automatic t_acc mul3(input logic signed [QW-1:0] a,
                                  input logic signed [QW-1:0] b,
                                  input logic signed [QW-1:0] c);
        t_acc wa, wb, wc;
        wa = a;
        wb = b;
        wc = c;
        return wa * wb * wc;
    endfunction

    // {clipped, value}
    function automatic logic [QW:0] clip32(input t_acc v);
        if (v > CLIP_HI)
            return {1'b1, S32_MAX};
        if (v < CLIP_LO)
            return {1'b1, S32_MIN};
        return {1'b0, v[QW-1:0]};
    endfunction

    function automatic t_out rotate_or_multiply(input t_in it);
        t_acc        sx, sy, sz, sw, cs;
        logic [QW:0] cx, cy, cz, cw;
        t_out        r;
        r  = '0;
        cs = 1;
        case (it.cmd)
            CMD_ROT, CMD_ROT_CONJ: begin
                // conjugate flips the sign of every term with exactly one w
                if (it.cmd == CMD_ROT_CONJ)
                    cs = -1;
                sx = - mul3(it.q_y, it.q_y, it.b_x) - mul3(it.q_z, it.q_z, it.b_x)
                     + mul3(it.q_x, it.q_y, it.b_y) - cs * mul3(it.q_w, it.q_z, it.b_y)
                     + cs * mul3(it.q_w, it.q_y, it.b_z) + mul3(it.q_x, it.q_z, it.b_z);
                sy =   cs * mul3(it.q_w, it.q_z, it.b_x) + mul3(it.q_x, it.q_y, it.b_x)
                     - mul3(it.q_x, it.q_x, it.b_y) - mul3(it.q_z, it.q_z, it.b_y)
                     + mul3(it.q_y, it.q_z, it.b_z) - cs * mul3(it.q_w, it.q_x, it.b_z);
                sz =   mul3(it.q_x, it.q_z, it.b_x) - cs * mul3(it.q_w, it.q_y, it.b_x)
                     + cs * mul3(it.q_w, it.q_x, it.b_y) + mul3(it.q_y, it.q_z, it.b_y)
                     - mul3(it.q_x, it.q_x, it.b_z) - mul3(it.q_y, it.q_y, it.b_z);
                // 2*S in q16.16, rounded half up, added to the vector
                cx = clip32(((sx + ROT_HALF) >>> ROT_SHIFT) + it.b_x);
                cy = clip32(((sy + ROT_HALF) >>> ROT_SHIFT) + it.b_y);
                cz = clip32(((sz + ROT_HALF) >>> ROT_SHIFT) + it.b_z);
                r.r_x       = cx[QW-1:0];
                r.r_y       = cy[QW-1:0];
                r.r_z       = cz[QW-1:0];
                r.saturated = cx[QW] | cy[QW] | cz[QW];
            end
            CMD_PROD: begin
                sw =   mul3(it.q_w, it.b_w, UNIT) - mul3(it.q_x, it.b_x, UNIT)
                     - mul3(it.q_y, it.b_y, UNIT) - mul3(it.q_z, it.b_z, UNIT);
                sx =   mul3(it.q_x, it.b_w, UNIT) + mul3(it.q_w, it.b_x, UNIT)
                     + mul3(it.q_y, it.b_z, UNIT) - mul3(it.q_z, it.b_y, UNIT);
                sy =   mul3(it.q_w, it.b_y, UNIT) - mul3(it.q_x, it.b_z, UNIT)
                     + mul3(it.q_y, it.b_w, UNIT) + mul3(it.q_z, it.b_x, UNIT);
                sz =   mul3(it.q_w, it.b_z, UNIT) + mul3(it.q_x, it.b_y, UNIT)
                     - mul3(it.q_y, it.b_x, UNIT) + mul3(it.q_z, it.b_w, UNIT);
                cw = clip32((sw + PROD_HALF) >>> PROD_SHIFT);
                cx = clip32((sx + PROD_HALF) >>> PROD_SHIFT);
                cy = clip32((sy + PROD_HALF) >>> PROD_SHIFT);
                cz = clip32((sz + PROD_HALF) >>> PROD_SHIFT);
                r.r_w       = cw[QW-1:0];
                r.r_x       = cx[QW-1:0];
                r.r_y       = cy[QW-1:0];
                r.r_z       = cz[QW-1:0];
                r.saturated = cw[QW] | cx[QW] | cy[QW] | cz[QW];
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 100)
            $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [QW-1:0] got,
                                 input logic [QW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s got %h want %h",
                                      n_checked, name, got, want));
    endtask

    // predicts on acceptance, checks on delivery
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_results.push_back(rotate_or_multiply(in_ch.data));
                n_by_cmd[in_ch.data.cmd]++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result item with no prediction waiting");
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("r_w", out_ch.data.r_w, want.r_w);
                    compare_field("r_x", out_ch.data.r_x, want.r_x);
                    compare_field("r_y", out_ch.data.r_y, want.r_y);
                    compare_field("r_z", out_ch.data.r_z, want.r_z);
                    compare_field("saturated", QW'(out_ch.data.saturated),
                                  QW'(want.saturated));
                    if (want.saturated)
                        n_saturated++;
                    n_checked++;
                end
            end
        end
    end

    // result sink picks a new stall pattern at random whenever the current phase runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            rdy_mode       <= RDY_ALWAYS;
            rdy_phase_left <= 0;
            rdy_tick       <= 0;
        end else begin
            rdy_tick <= rdy_tick + 1;
            if (rdy_phase_left == 0) begin
                rdy_mode       <= t_rdy_mode'($urandom_range(3, 0));
                rdy_phase_left <= $urandom_range(120, 20);
            end else begin
                rdy_phase_left <= rdy_phase_left - 1;
            end
            case (rdy_mode)
                RDY_ALWAYS:   out_ch.ready <= 1'b1;
                RDY_SPARSE:   out_ch.ready <= ($urandom_range(2, 0) != 0);
                RDY_PERIODIC: out_ch.ready <= (rdy_tick % 5 < 3);
                RDY_CHOKED:   out_ch.ready <= ($urandom_range(7, 0) == 0);
                default:      out_ch.ready <= 1'b1;
            endcase
        end
    end

    task automatic send_item(input t_in it);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // long bursts now and then give stretches with no gaps at all
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 0);
            gap        = ($urandom_range(4, 0) == 0) ? $urandom_range(15, 4)
                                                     : $urandom_range(3, 0);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_in make_item(input logic [1:0] cmd,
                                      input logic signed [QW-1:0] qw,
                                      input logic signed [QW-1:0] qx,
                                      input logic signed [QW-1:0] qy,
                                      input logic signed [QW-1:0] qz,
                                      input logic signed [QW-1:0] bw,
                                      input logic signed [QW-1:0] bx,
                                      input logic signed [QW-1:0] by,
                                      input logic signed [QW-1:0] bz);
        t_in it;
        it.cmd = cmd;
        it.q_w = qw;
        it.q_x = qx;
        it.q_y = qy;
        it.q_z = qz;
        it.b_w = bw;
        it.b_x = bx;
        it.b_y = by;
        it.b_z = bz;
        return it;
    endfunction

    // vector fields use a q16.16 scale, quaternion fields a q2.30 one
    function automatic logic signed [QW-1:0] pick_component(input bit is_vec);
        logic signed [QW-1:0] v;
        case ($urandom_range(9, 0))
            6, 7: v = $urandom;
            8: begin
                case ($urandom_range(7, 0))
                    0: v = S32_MAX;
                    1: v = S32_MIN;
                    2: v = '0;
                    3: v = -1;
                    4: v = 1;
                    5: v = ONE_Q30;
                    6: v = -ONE_Q30;
                    default: v = ONE_Q16;
                endcase
            end
            9: v = $signed($urandom_range(32, 0)) - 16;
            default: begin
                if (is_vec)
                    v = $urandom_range(32'h0100_0000, 0) - 32'h0080_0000;
                else
                    v = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
            end
        endcase
        return v;
    endfunction

    task automatic test_field_extremes();
        send_item(make_item(CMD_ROT, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX, S32_MAX, S32_MAX));
        send_item(make_item(CMD_ROT_CONJ, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX, S32_MAX, S32_MAX));
        send_item(make_item(CMD_PROD, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                            S32_MAX, S32_MAX, S32_MAX, S32_MAX));
        send_item(make_item(CMD_ROT, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                            S32_MIN, S32_MIN, S32_MIN, S32_MIN));
        send_item(make_item(CMD_ROT_CONJ, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                            S32_MIN, S32_MIN, S32_MIN, S32_MIN));
        send_item(make_item(CMD_PROD, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                            S32_MIN, S32_MIN, S32_MIN, S32_MIN));
        send_item(make_item(CMD_ROT, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(CMD_PROD, S32_MIN, S32_MAX, S32_MIN, S32_MAX,
                            S32_MAX, S32_MIN, S32_MAX, S32_MIN));
    endtask

    task automatic test_each_command();
        // identity leaves the vector alone
        send_item(make_item(CMD_ROT, ONE_Q30, '0, '0, '0,
                            32'sd12345, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16));
        // quarter turn about z, and the opposite turn through the conjugate
        send_item(make_item(CMD_ROT, COS45_Q30, '0, '0, COS45_Q30,
                            '0, ONE_Q16, '0, '0));
        send_item(make_item(CMD_ROT_CONJ, COS45_Q30, '0, '0, COS45_Q30,
                            '0, ONE_Q16, '0, '0));
        send_item(make_item(CMD_PROD, COS45_Q30, COS45_Q30, '0, '0,
                            COS45_Q30, '0, COS45_Q30, '0));
        send_item(make_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_corner_cases();
        // conjugate of the most negative components must not wrap
        send_item(make_item(CMD_ROT_CONJ, S32_MIN, S32_MIN, '0, S32_MIN,
                            '0, ONE_Q16, -ONE_Q16, ONE_Q16));
        send_item(make_item(CMD_ROT_CONJ, S32_MIN, 32'sh0000_4000, 32'sh0000_4000, '0,
                            '0, 32'sd1, 32'sd1, 32'sd1));
        // rotation sums landing exactly on half a step, both signs
        send_item(make_item(CMD_ROT, '0, '0, 32'sh0000_4000, '0,
                            '0, ONE_Q30, '0, '0));
        send_item(make_item(CMD_ROT, '0, 32'sh0000_4000, 32'sh0000_4000, '0,
                            '0, '0, ONE_Q30, '0));
        // product sums on half a step, both signs
        send_item(make_item(CMD_PROD, 32'sd1, '0, '0, '0,
                            32'sh2000_0000, '0, '0, '0));
        send_item(make_item(CMD_PROD, -32'sd1, '0, '0, '0,
                            32'sh2000_0000, '0, '0, '0));
    endtask

    task automatic test_random_items();
        int   k;
        t_in  it;
        logic [1:0] cmd;
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(19, 0))
                0:                     cmd = CMD_UNUSED;
                1, 2, 3, 4, 5, 6:      cmd = CMD_ROT;
                7, 8, 9, 10, 11, 12:   cmd = CMD_ROT_CONJ;
                default:               cmd = CMD_PROD;
            endcase
            it = make_item(cmd, pick_component(1'b0), pick_component(1'b0),
                           pick_component(1'b0), pick_component(1'b0),
                           pick_component(1'b0),
                           pick_component(cmd != CMD_PROD),
                           pick_component(cmd != CMD_PROD),
                           pick_component(cmd != CMD_PROD));
            send_item(it);
        end
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_mismatch   = 0;
        n_checked    = 0;
        n_saturated  = 0;
        n_by_cmd     = '{default: 0};
        burst_left   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_each_command();
        test_corner_cases();
        test_random_items();

        in_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (NST + 4) @(posedge i_clk);

        $display("items: %0d rotate, %0d conjugate rotate, %0d product, %0d unused command",
                 n_by_cmd[CMD_ROT], n_by_cmd[CMD_ROT_CONJ], n_by_cmd[CMD_PROD],
                 n_by_cmd[CMD_UNUSED]);
        $display("%0d results checked, %0d saturated, %0d mismatches",
                 n_checked, n_saturated, n_mismatch);
        if (n_mismatch == 0)
            $display("tb_quaternion_rotate_and_multiply: PASS");
        else
            $display("tb_quaternion_rotate_and_multiply: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d results outstanding", predicted_results.size());
        $display("tb_quaternion_rotate_and_multiply: FAIL");
        $finish;
    end

endmodule
